// ===== rtl/fbds_pkg.sv =====
// shared types and constants for the fractional baud divisor search
// no dependencies
package fbds_pkg;

   localparam int CLK_W  = 28;
   localparam int BAUD_W = 24;
   localparam int DIV_W  = 17;
   localparam int MD_W   = 4;
   localparam int PCT_W  = 8;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_HIGH   = 2'd1,
      STATUS_NONE   = 2'd2,
      STATUS_UNUSED = 2'd3
   } status_type;

   // one queued job: request plus clock snapshot
   typedef struct packed {
      logic [BAUD_W-1:0] baud;
      logic [CLK_W-1:0]  clk;
   } job_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CAND,
      ST_CDIV,
      ST_CEVAL,
      ST_AMUL,
      ST_ADIV,
      ST_PMUL,
      ST_PDIV,
      ST_DONE
   } state_type;

   localparam logic [31:0] HALF = 32'h8000_0000;

endpackage

// ===== rtl/fbds_divider.sv =====
// shared restoring divider, one quotient bit per cycle
// depends on fbds_pkg
module fbds_divider
   import fbds_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [31:0] divisor,
   output logic        busy,
   output logic [63:0] quotient
);

   logic [63:0] quo_ff, quo_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] den_ff, den_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [32:0] trial;

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      trial  = '0;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         den_in = divisor;
         cnt_in = 7'd64;
      end else if (cnt_ff != 7'd0) begin
         trial = {rem_ff[31:0], quo_ff[63]};
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign busy     = (cnt_ff != 7'd0);
   assign quotient = quo_ff;

endmodule

// ===== rtl/fbds_front.sv =====
// front: takes requests, snapshots the clock register, two-entry job queue
// depends on fbds_pkg
module fbds_front
   import fbds_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [BAUD_W-1:0] req_baud_rate,
   input  logic [CLK_W-1:0]  sys_clk,
   output logic              job_valid,
   output job_type           job,
   input  logic              job_take
);

   job_type     mem_ff [2];
   logic [1:0]  cnt_ff, cnt_in;
   logic        wp_ff, rp_ff;
   logic        push, pop;

   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign job_valid = (cnt_ff != 2'd0);
   assign pop       = job_valid && job_take;
   assign job       = mem_ff[rp_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) cnt_in = cnt_ff + 2'd1;
      else if (pop && !push) cnt_in = cnt_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) wp_ff <= !wp_ff;
         if (pop) rp_ff <= !rp_ff;
      end
      if (push) mem_ff[wp_ff] <= '{baud: req_baud_rate, clk: sys_clk};
   end

   a_count: assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'd2)
      else $error("queue overflow");
   a_pop: assert property (@(posedge clock) disable iff (reset) pop |-> cnt_ff != 2'd0)
      else $error("pop from empty queue");
   a_full: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2 && !pop) |=> cnt_ff == 2'd2)
      else $error("full queue lost entry");

endmodule

// ===== rtl/fbds_back.sv =====
// back: sequential candidate search and actual-rate / percent computation
// depends on fbds_pkg, fbds_divider
module fbds_back
   import fbds_pkg::*;
#(
   parameter int MAX_MULTIPLIER = 15,
   parameter int MAX_DIVISOR    = 65536
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   input  job_type           job,
   output logic              job_take,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_status,
   output logic [DIV_W-1:0]  rsp_divisor,
   output logic [7:0]        rsp_divisor_high_byte,
   output logic [7:0]        rsp_divisor_low_byte,
   output logic [MD_W-1:0]   rsp_mul_value,
   output logic [MD_W-1:0]   rsp_divadd_value,
   output logic [BAUD_W-1:0] rsp_actual_baud,
   output logic [PCT_W-1:0]  rsp_error_percent
);

   state_type state_ff, state_in;
   logic [BAUD_W-1:0] baud_ff;
   logic [25:0]       pclk_ff;
   logic [MD_W-1:0]   m_ff, d_ff, bm_ff, bd_ff;
   logic [31:0]       berr_ff;
   logic [DIV_W-1:0]  bdiv_ff;
   logic              found_ff;
   logic [BAUD_W-1:0] act_ff;
   logic [PCT_W-1:0]  pct_ff;
   logic              out_v_ff;
   logic [1:0]        o_st_ff;
   logic [DIV_W-1:0]  o_div_ff;
   logic [MD_W-1:0]   o_m_ff, o_d_ff;
   logic [BAUD_W-1:0] o_act_ff;
   logic [PCT_W-1:0]  o_pct_ff;

   logic        dv_start, dv_busy;
   logic [63:0] dv_q;
   logic [63:0] dv_dividend;
   logic [31:0] dv_divisor;
   logic [31:0] frac, err;
   logic [32:0] whole;
   logic        in_range, better, last_d, last_m;
   logic [BAUD_W-1:0] diff;

   fbds_divider u_div (
      .clock(clock), .reset(reset), .start(dv_start),
      .dividend(dv_dividend), .divisor(dv_divisor), .busy(dv_busy), .quotient(dv_q)
   );

   always_comb begin
      frac  = dv_q[31:0];
      whole = {1'b0, dv_q[63:32]};
      err   = frac;
      if (frac > HALF) begin
         err   = 32'd0 - frac;
         whole = whole + 33'd1;
      end
      in_range = (whole >= 33'd1) && (whole <= 33'(MAX_DIVISOR));
      better   = in_range && (err < berr_ff);
      last_d   = (d_ff == m_ff - 4'd1);
      last_m   = (m_ff == MD_W'(MAX_MULTIPLIER));
      diff     = (baud_ff > act_ff) ? baud_ff - act_ff : act_ff - baud_ff;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (job_valid && !out_v_ff) state_in =
                      (job.baud == '0) ? ST_DONE : ST_CAND;
         ST_CAND:  state_in = ST_CDIV;
         ST_CDIV:  if (!dv_busy) state_in = ST_CEVAL;
         ST_CEVAL: begin
            if ((better && err == 32'd0) || (last_d && last_m))
               state_in = (found_ff || better) ? ST_AMUL : ST_DONE;
            else
               state_in = ST_CAND;
         end
         ST_AMUL:  state_in = ST_ADIV;
         ST_ADIV:  if (!dv_busy) state_in = ST_PMUL;
         ST_PMUL:  state_in = ST_PDIV;
         ST_PDIV:  if (!dv_busy) state_in = ST_DONE;
         ST_DONE:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      job_take = (state_ff == ST_IDLE) && job_valid && !out_v_ff;
      dv_start = (state_ff == ST_CAND) || (state_ff == ST_AMUL) || (state_ff == ST_PMUL);
      dv_dividend = '0;
      dv_divisor  = '0;
      // operands go straight into the divider on its start cycle
      unique case (state_ff)
         ST_CAND: begin
            dv_dividend = {10'd0, pclk_ff, 28'd0} * 64'(m_ff);
            dv_divisor  = 32'(baud_ff) * 32'(5'(m_ff) + 5'(d_ff));
         end
         ST_AMUL: begin
            dv_dividend = 64'(pclk_ff[25:4]) * 64'(bm_ff);
            dv_divisor  = 32'(bdiv_ff) * 32'(5'(bm_ff) + 5'(bd_ff));
         end
         ST_PMUL: begin
            dv_dividend = 64'(diff) * 64'd100;
            dv_divisor  = 32'(baud_ff);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_valid && !rsp_stall) out_v_ff <= 1'b0;
         if (state_ff == ST_DONE) out_v_ff <= 1'b1;
      end
      unique case (state_ff)
         ST_IDLE: begin
            baud_ff  <= job.baud;
            pclk_ff  <= job.clk[CLK_W-1:2];
            m_ff     <= 4'd1;
            d_ff     <= 4'd0;
            berr_ff  <= 32'hFFFF_FFFF;
            found_ff <= 1'b0;
            bdiv_ff  <= '0;
            bm_ff    <= '0;
            bd_ff    <= '0;
            act_ff   <= '0;
            pct_ff   <= '0;
         end
         ST_CEVAL: begin
            if (better) begin
               berr_ff  <= err;
               bdiv_ff  <= whole[DIV_W-1:0];
               bm_ff    <= m_ff;
               bd_ff    <= d_ff;
               found_ff <= 1'b1;
            end
            if (last_d) begin
               m_ff <= m_ff + 4'd1;
               d_ff <= 4'd0;
            end else begin
               d_ff <= d_ff + 4'd1;
            end
            pct_ff <= 8'd100;
         end
         ST_ADIV: if (!dv_busy) act_ff <= dv_q[BAUD_W-1:0];
         ST_PDIV: if (!dv_busy)
            pct_ff <= (dv_q > 64'd255) ? 8'd255 : dv_q[7:0];
         ST_DONE: begin
            o_div_ff <= bdiv_ff;
            o_m_ff   <= bm_ff;
            o_d_ff   <= bd_ff;
            o_act_ff <= act_ff;
            o_pct_ff <= pct_ff;
            o_st_ff  <= !found_ff ? STATUS_NONE :
                        (pct_ff < 8'd3) ? STATUS_OK : STATUS_HIGH;
         end
         default: ;
      endcase
   end

   assign rsp_valid             = out_v_ff;
   assign rsp_status            = o_st_ff;
   assign rsp_divisor           = o_div_ff;
   assign rsp_divisor_high_byte = o_div_ff[15:8];
   assign rsp_divisor_low_byte  = o_div_ff[7:0];
   assign rsp_mul_value         = o_m_ff;
   assign rsp_divadd_value      = o_d_ff;
   assign rsp_actual_baud       = o_act_ff;
   assign rsp_error_percent     = o_pct_ff;

   a_take: assert property (@(posedge clock) disable iff (reset)
      job_take |-> state_ff == ST_IDLE && !out_v_ff)
      else $error("job taken while busy");
   a_dchk: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CEVAL |-> d_ff < m_ff)
      else $error("addend not below multiplier");
   a_none: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_NONE) |-> rsp_divisor == '0)
      else $error("divisor on no-divisor status");

endmodule

// ===== rtl/fractional_baud_divisor_search.sv =====
// top level of the fractional baud divisor search
// depends on fbds_pkg, fbds_front, fbds_back, fbds_divider
//
// usage: write the system clock in hertz on the csr_ channel (valid/ready,
// always ready) while idle. each request on req_ carries a baud rate; the
// front queues up to two requests with a snapshot of the clock register.
// the back steps through multiplier/addend candidates one at a time; each
// candidate takes a divide on the shared restoring divider, and two more
// divides give the actual rate and percent. one result per request on
// rsp_; it is held in an output register while rsp_stall is high, and the
// back takes no new job until it leaves. reset is synchronous and empties
// the queue, drops any pending result and restores the clock register to
// 100 MHz.
module fractional_baud_divisor_search
   import fbds_pkg::*;
#(
   parameter int MAX_MULTIPLIER = 15,
   parameter int MAX_DIVISOR    = 65536
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [CLK_W-1:0]  csr_system_clock_hz,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [BAUD_W-1:0] req_baud_rate,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_status,
   output logic [DIV_W-1:0]  rsp_divisor,
   output logic [7:0]        rsp_divisor_high_byte,
   output logic [7:0]        rsp_divisor_low_byte,
   output logic [MD_W-1:0]   rsp_mul_value,
   output logic [MD_W-1:0]   rsp_divadd_value,
   output logic [BAUD_W-1:0] rsp_actual_baud,
   output logic [PCT_W-1:0]  rsp_error_percent
);

   logic [CLK_W-1:0] clk_hz_ff;
   logic             job_valid, job_take;
   job_type          job;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         clk_hz_ff <= CLK_W'(100000000);
      end else if (csr_valid && csr_ready) begin
         clk_hz_ff <= csr_system_clock_hz;
      end
   end

   fbds_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_baud_rate(req_baud_rate),
      .sys_clk(clk_hz_ff),
      .job_valid(job_valid), .job(job), .job_take(job_take)
   );

   fbds_back #(
      .MAX_MULTIPLIER(MAX_MULTIPLIER), .MAX_DIVISOR(MAX_DIVISOR)
   ) u_back (
      .clock(clock), .reset(reset),
      .job_valid(job_valid), .job(job), .job_take(job_take),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_status(rsp_status), .rsp_divisor(rsp_divisor),
      .rsp_divisor_high_byte(rsp_divisor_high_byte),
      .rsp_divisor_low_byte(rsp_divisor_low_byte),
      .rsp_mul_value(rsp_mul_value), .rsp_divadd_value(rsp_divadd_value),
      .rsp_actual_baud(rsp_actual_baud), .rsp_error_percent(rsp_error_percent)
   );

endmodule
